FILE: rtl/core/assert_macros.svh
// Assertion helper macros for the RTL in this folder.
// No dependencies; include by bare file name inside a module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/esort_pkg.sv
// Shared constants and types for the exchange sort engine.
// No dependencies; used by the channel interfaces, the engine and the testbench.
`default_nettype none

package esort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic signed [DATA_W-1:0] t_elem;
    typedef logic        [ADDR_W-1:0] t_addr;
    typedef logic        [CNT_W-1:0]  t_cnt;

    localparam t_cnt MAX_CNT = CNT_W'(MAX_ITEMS);

endpackage

`default_nettype wire

FILE: rtl/core/esort_in_if.sv
// Input channel: one element word per handshake, plus the end-of-set mark.
// Depends on esort_pkg.
`default_nettype none

interface esort_in_if import esort_pkg::*; ();
    logic  valid;
    logic  ready;
    t_elem value;
    logic  is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/esort_out_if.sv
// Output channel: one sorted word per handshake, flagged on the final word.
// Depends on esort_pkg.
`default_nettype none

interface esort_out_if import esort_pkg::*; ();
    logic  valid;
    logic  ready;
    t_elem sorted_value;
    logic  end_of_set;

    modport source (output valid, output sorted_value, output end_of_set, input ready);
    modport sink   (input valid, input sorted_value, input end_of_set, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/esort_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module esort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/exchange_sort_engine.sv
// Exchange sort engine. Words are loaded one per cycle into a MAX_ITEMS-entry
// store; words that arrive with the store full are dropped. The word marked
// is_last starts the sort: for every pair (i, j) of loaded entries, i and j are
// swapped when entry i is less than entry j (signed), which leaves the set in
// ascending order. The input is not ready from the is_last word until the last
// sorted word has been loaded into the output register. The sort does one
// compare-swap per cycle through a single comparator, with entry i held in a
// register and entry j streamed through the store's read port while swaps go
// back through its write port. Each word is emitted by a store read, then an
// output register load once that register is free. The last word may still
// wait in the output register while the next set loads.
// Depends on esort_pkg, esort_in_if, esort_out_if, esort_ram, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module exchange_sort_engine import esort_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    esort_in_if.sink    i_in,
    esort_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_LD_I,
        S_CMP,
        S_WB,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state r_state;
    t_cnt   r_fill;
    t_cnt   r_n;
    t_addr  r_i;
    t_addr  r_jq;     // index of the word now on the read data bus
    t_addr  r_k;
    t_elem  r_ei;     // live copy of entry i during its pass
    logic   r_out_valid;
    t_elem  r_out_value;
    logic   r_out_last;

    logic        ram_we;
    t_addr       ram_waddr;
    t_elem       ram_wdata;
    t_addr       ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    t_elem       rd_elem;

    logic in_acc;
    logic out_free;
    logic room;
    logic swap;
    logic jq_last;
    logic i_last;
    logic k_last;

    esort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_elem  = t_elem'(ram_rdata);
    assign in_acc   = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;
    assign room     = (r_fill < MAX_CNT);
    assign jq_last  = ((CNT_W'(r_jq) + CNT_W'(1)) == r_n);
    assign i_last   = ((CNT_W'(r_i) + CNT_W'(1)) == r_n);
    assign k_last   = ((CNT_W'(r_k) + CNT_W'(1)) == r_n);
    // entry i against itself never swaps; its store copy is stale during the pass
    assign swap     = (r_state == S_CMP) && (r_jq != r_i) && (r_ei < rd_elem);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_ei;
        ram_raddr = '0;
        case (r_state)
            S_IDLE: begin
                ram_we    = in_acc && room;
                ram_waddr = r_fill[ADDR_W-1:0];
                ram_wdata = i_in.value;
            end
            S_CMP: begin
                ram_raddr = r_jq + ADDR_W'(1);
                ram_we    = swap;
                ram_waddr = r_jq;
            end
            S_WB: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_raddr = r_i + ADDR_W'(1);
            end
            S_EMIT_RD: begin
                ram_raddr = r_k;
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_n         <= '0;
            r_i         <= '0;
            r_jq        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.is_last) begin
                            r_n     <= room ? (r_fill + CNT_W'(1)) : r_fill;
                            r_fill  <= '0;
                            r_i     <= '0;
                            r_state <= S_START;
                        end else if (room) begin
                            r_fill <= r_fill + CNT_W'(1);
                        end
                    end
                end
                S_START: begin
                    r_state <= S_LD_I;
                end
                S_LD_I: begin
                    r_ei    <= rd_elem;
                    r_jq    <= '0;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (swap) begin
                        r_ei <= rd_elem;
                    end
                    if (jq_last) begin
                        r_state <= S_WB;
                    end else begin
                        r_jq <= r_jq + ADDR_W'(1);
                    end
                end
                S_WB: begin
                    if (i_last) begin
                        r_k     <= '0;
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_i     <= r_i + ADDR_W'(1);
                        r_state <= S_LD_I;
                    end
                end
                S_EMIT_RD: begin
                    if (out_free) begin
                        r_state <= S_EMIT_LD;
                    end
                end
                S_EMIT_LD: begin
                    r_out_valid <= 1'b1;
                    r_out_value <= rd_elem;
                    r_out_last  <= k_last;
                    if (k_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + ADDR_W'(1);
                        r_state <= S_EMIT_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.end_of_set   = r_out_last;

    `ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= MAX_CNT)
    `ASSERT_IMP(a_set_nonempty, i_clk, i_rst_n, r_state != S_IDLE, r_n != '0)
    `ASSERT_IMP(a_jq_in_set, i_clk, i_rst_n, r_state == S_CMP, CNT_W'(r_jq) < r_n)
    `ASSERT_IMP(a_out_slot_free, i_clk, i_rst_n, r_state == S_EMIT_LD, !r_out_valid)
    `ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, (r_state == S_EMIT_LD) && k_last,
                (r_state == S_IDLE) && r_out_valid && r_out_last)

endmodule

`default_nettype wire

FILE: sim/esort_checker.sv
`timescale 1ns / 100ps
// Checker for the exchange sort engine: tracks the words loaded into the set,
// orders them when the end-of-set word arrives and compares every output word.
// Depends on esort_pkg, esort_in_if and esort_out_if.
module esort_checker import esort_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    esort_in_if  i_in,
    esort_out_if i_out,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_elem value;
        logic  last;
    } t_sorted_word;

    t_elem        set_words [MAX_ITEMS];
    int           set_len = 0;
    int           fails   = 0;
    t_sorted_word sorted_q [$];

    always @(posedge i_clk) begin : track
        t_sorted_word want;
        t_elem        swap_tmp;
        if (!i_rst_n) begin
            set_len = 0;
            sorted_q.delete();
        end else begin
            // output side first, so a word can never match one queued this same edge
            if (i_out.valid && i_out.ready) begin
                if (sorted_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: unexpected word: value %0d end %0b, nothing pending",
                                 $realtime, i_out.sorted_value, i_out.end_of_set);
                end else begin
                    want = sorted_q.pop_front();
                    if (i_out.sorted_value !== want.value ||
                        i_out.end_of_set !== want.last) begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected value %0d end %0b, got value %0d end %0b",
                                     $realtime, want.value, want.last,
                                     i_out.sorted_value, i_out.end_of_set);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                // words arriving with the store full are dropped, even the last one
                if (set_len < MAX_ITEMS) begin
                    set_words[set_len] = i_in.value;
                    set_len++;
                end
                if (i_in.is_last) begin
                    for (int i = 0; i < set_len; i++) begin
                        for (int j = 0; j < set_len; j++) begin
                            if (set_words[i] < set_words[j]) begin
                                swap_tmp     = set_words[i];
                                set_words[i] = set_words[j];
                                set_words[j] = swap_tmp;
                            end
                        end
                    end
                    for (int k = 0; k < set_len; k++)
                        sorted_q.push_back('{value: set_words[k], last: (k == set_len - 1)});
                    set_len = 0;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= sorted_q.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Top of the exchange sort engine testbench: clock, reset, word stimulus and
// receiver stalls; checking is done by esort_checker.
// Depends on esort_pkg, esort_in_if, esort_out_if, exchange_sort_engine, esort_checker.
module tb;
    import esort_pkg::*;

    localparam int    TOTAL_WORDS  = 270;
    localparam int    DRAIN_CYCLES = 50;
    localparam int    LONG_HOLD    = 400;
    localparam int    LONG_HOLDS   = 3;
    localparam t_elem ELEM_MAX     = 32'sh7FFF_FFFF;
    localparam t_elem ELEM_MIN     = 32'sh8000_0000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   burst_left = 0;
    int   words_sent = 0;

    esort_in_if  u_in_if ();
    esort_out_if u_out_if ();

    exchange_sort_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    esort_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (u_in_if),
        .i_out        (u_out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: stall pattern changes periodically; a few long hold-offs
    // while a set is coming out back up the block into its input
    initial begin : receiver
        int tick;
        int mode;
        int hold_left;
        int holds_done;
        int next_hold;
        tick       = 0;
        mode       = 0;
        hold_left  = 0;
        holds_done = 0;
        next_hold  = 200;
        u_out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_left != 0) begin
                hold_left--;
                u_out_if.ready <= 1'b0;
            end else if (u_out_if.valid && holds_done < LONG_HOLDS && tick >= next_hold) begin
                holds_done++;
                next_hold = tick + 2500;
                hold_left = LONG_HOLD;
                u_out_if.ready <= 1'b0;
            end else begin
                if (tick % 64 == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0:       u_out_if.ready <= 1'b1;
                    1:       u_out_if.ready <= 1'($urandom_range(0, 1));
                    default: u_out_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // extremes and tiny ranges often, so sets get duplicates and sign flips
    function automatic t_elem pick_word();
        case ($urandom_range(0, 7))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            2:       return t_elem'($signed($urandom_range(0, 8)) - 4);
            default: return t_elem'($urandom);
        endcase
    endfunction

    // sender works in bursts; valid drops only when a gap is actually taken
    task automatic send_word(input t_elem value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                u_in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        u_in_if.valid   <= 1'b1;
        u_in_if.value   <= value;
        u_in_if.is_last <= last;
        @(posedge i_clk);
        while (!u_in_if.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_set(input int len);
        for (int k = 0; k < len; k++)
            send_word(pick_word(), k == len - 1);
    endtask

    initial begin : stimulus
        int len;
        int kind;
        i_rst_n         <= 1'b0;
        u_in_if.valid   <= 1'b0;
        u_in_if.value   <= '0;
        u_in_if.is_last <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-word sets at both extremes
        send_word(ELEM_MAX, 1'b1);
        send_word(ELEM_MIN, 1'b1);
        // mixed signs, repeats and alternating bit patterns
        send_word(32'sh0000_0000, 1'b0);
        send_word(32'shFFFF_FFFF, 1'b0);
        send_word(32'sh0000_0001, 1'b0);
        send_word(ELEM_MAX, 1'b0);
        send_word(ELEM_MIN, 1'b0);
        send_word(ELEM_MAX, 1'b0);
        send_word(ELEM_MIN, 1'b0);
        send_word(32'sh5555_5555, 1'b0);
        send_word(32'shAAAA_AAAA, 1'b1);
        // already ascending
        send_word(-32'sd3, 1'b0);
        send_word(-32'sd2, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd0, 1'b0);
        send_word(32'sd1, 1'b0);
        send_word(32'sd2, 1'b1);
        // descending
        send_word(32'sd5, 1'b0);
        send_word(32'sd4, 1'b0);
        send_word(32'sd3, 1'b0);
        send_word(32'sd2, 1'b0);
        send_word(32'sd1, 1'b1);

        // store exactly full, then overflow where the end-of-set word is dropped
        send_set(MAX_ITEMS);
        send_set(MAX_ITEMS + 2);
        while (words_sent < TOTAL_WORDS) begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
                len = MAX_ITEMS;
            else if (kind == 1)
                len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
            else
                len = $urandom_range(1, 12);
            send_set(len);
        end
        u_in_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
